@@ src/mtep_pkg.sv @@
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants shared by the track event parser modules.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned VLQ_W  = 28;
  localparam int unsigned HEAD_W = 32;

  localparam logic [7:0] STATUS_BIT  = 8'h80;
  localparam logic [7:0] DATA_MASK   = 8'h7F;
  localparam logic [7:0] SYS_BASE    = 8'hF0;
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_CONT  = 8'hF7;
  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [3:0] TOP_PROGRAM = 4'hC;
  localparam logic [3:0] TOP_CHPRESS = 4'hD;
  localparam logic [3:0] TOP_NOTEOFF = 4'h8;

  typedef enum logic [3:0] {
    KIND_NOTEOFF   = 4'd0,
    KIND_NOTEON    = 4'd1,
    KIND_POLYPRESS = 4'd2,
    KIND_CONTROL   = 4'd3,
    KIND_PROGRAM   = 4'd4,
    KIND_CHANPRESS = 4'd5,
    KIND_BEND      = 4'd6,
    KIND_META      = 4'd7,
    KIND_SYSEX     = 4'd8,
    KIND_BAD       = 4'd9
  } kind_t;

  typedef enum logic [8:0] {
    PH_DELTA  = 9'b000000001,
    PH_STATUS = 9'b000000010,
    PH_DATA1  = 9'b000000100,
    PH_DATA2  = 9'b000001000,
    PH_MTYPE  = 9'b000010000,
    PH_MLEN   = 9'b000100000,
    PH_MBODY  = 9'b001000000,
    PH_SLEN   = 9'b010000000,
    PH_SBODY  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
  } mtep_in_t;

  typedef struct packed {
    logic [3:0]        kind;
    logic [3:0]        channel;
    logic [6:0]        first_data;
    logic [6:0]        second_data;
    logic [6:0]        meta_kind;
    logic [VLQ_W-1:0]  body_length;
    logic [HEAD_W-1:0] meta_head;
    logic [VLQ_W-1:0]  delta_ticks;
  } mtep_out_t;

endpackage

@@ src/mtep_core.sv @@
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and the per-byte update; flags a record when an event ends.
// ----------------------------------------------------------------------------
module mtep_core import mtep_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  mtep_in_t  item,
  output logic      res_valid,
  output mtep_out_t res
);

  phase_t            phase_r, phase_nxt, ph_e;
  logic [7:0]        rs_r, rs_nxt, rs_e;
  logic [VLQ_W-1:0]  delta_r, delta_nxt, delta_e;
  logic [6:0]        hfd_r, hfd_nxt, hfd_e;
  logic [6:0]        hmk_r, hmk_nxt, hmk_e;
  logic [VLQ_W-1:0]  len_r, len_nxt, len_e;
  logic [VLQ_W-1:0]  left_r, left_nxt, left_e;
  logic [HEAD_W-1:0] head_r, head_nxt, head_e;

  logic [7:0]       b;
  logic             is_status;
  logic [VLQ_W-1:0] len_shift;
  logic [VLQ_W-1:0] left_dec;
  logic [VLQ_W-1:0] taken;
  logic [3:0]       rs_top;

  assign b         = item.data_byte;
  assign is_status = (b & STATUS_BIT) != 8'h00;
  assign len_shift = {len_e[VLQ_W-8:0], b[6:0]};
  assign left_dec  = left_e - VLQ_W'(1);
  assign taken     = len_e - left_e;
  assign rs_top    = rs_e[7:4];

  always_comb begin
    ph_e    = item.track_start ? PH_DELTA : phase_r;
    rs_e    = item.track_start ? 8'h00 : rs_r;
    delta_e = item.track_start ? '0 : delta_r;
    hfd_e   = item.track_start ? '0 : hfd_r;
    hmk_e   = item.track_start ? '0 : hmk_r;
    len_e   = item.track_start ? '0 : len_r;
    left_e  = item.track_start ? '0 : left_r;
    head_e  = item.track_start ? '0 : head_r;
  end

  always_comb begin
    phase_nxt = ph_e;
    rs_nxt    = rs_e;
    delta_nxt = delta_e;
    hfd_nxt   = hfd_e;
    hmk_nxt   = hmk_e;
    len_nxt   = len_e;
    left_nxt  = left_e;
    head_nxt  = head_e;
    res_valid = 1'b0;
    res       = '0;
    res.delta_ticks = delta_e;

    unique case (ph_e)
      PH_STATUS: begin
        if (is_status) begin
          if (b < SYS_BASE) begin
            rs_nxt    = b;
            phase_nxt = PH_DATA1;
          end else begin
            rs_nxt = 8'h00;
            if (b == META_STATUS) begin
              phase_nxt = PH_MTYPE;
            end else if (b == SYSEX_START || b == SYSEX_CONT) begin
              len_nxt   = '0;
              phase_nxt = PH_SLEN;
            end else begin
              res_valid      = 1'b1;
              res.kind       = KIND_BAD;
              res.first_data = b[6:0];
            end
          end
        end else if (rs_e == 8'h00) begin
          res_valid      = 1'b1;
          res.kind       = KIND_BAD;
          res.first_data = b[6:0];
        end else if (rs_top == TOP_PROGRAM || rs_top == TOP_CHPRESS) begin
          res_valid      = 1'b1;
          res.kind       = rs_top - TOP_NOTEOFF;
          res.channel    = rs_e[3:0];
          res.first_data = b[6:0];
        end else begin
          hfd_nxt   = b[6:0];
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA1: begin
        if (is_status) begin
          res_valid      = 1'b1;
          res.kind       = KIND_BAD;
          res.first_data = b[6:0];
        end else if (rs_top == TOP_PROGRAM || rs_top == TOP_CHPRESS) begin
          res_valid      = 1'b1;
          res.kind       = rs_top - TOP_NOTEOFF;
          res.channel    = rs_e[3:0];
          res.first_data = b[6:0];
        end else begin
          hfd_nxt   = b[6:0];
          phase_nxt = PH_DATA2;
        end
      end
      PH_DATA2: begin
        res_valid = 1'b1;
        if (is_status) begin
          res.kind       = KIND_BAD;
          res.first_data = b[6:0];
        end else begin
          res.kind        = rs_top - TOP_NOTEOFF;
          res.channel     = rs_e[3:0];
          res.first_data  = hfd_e;
          res.second_data = b[6:0];
        end
      end
      PH_MTYPE: begin
        if (is_status) begin
          res_valid      = 1'b1;
          res.kind       = KIND_BAD;
          res.first_data = b[6:0];
        end else begin
          hmk_nxt   = b[6:0];
          len_nxt   = '0;
          phase_nxt = PH_MLEN;
        end
      end
      PH_MLEN, PH_SLEN: begin
        len_nxt = len_shift;
        if (!is_status) begin
          left_nxt = len_shift;
          head_nxt = '0;
          if (len_shift == '0) begin
            res_valid = 1'b1;
            if (ph_e == PH_MLEN) begin
              res.kind      = KIND_META;
              res.meta_kind = hmk_e;
            end else begin
              res.kind = KIND_SYSEX;
            end
          end else begin
            phase_nxt = (ph_e == PH_MLEN) ? PH_MBODY : PH_SBODY;
          end
        end
      end
      PH_MBODY, PH_SBODY: begin
        if (ph_e == PH_MBODY && taken < VLQ_W'(4)) begin
          head_nxt = {head_e[HEAD_W-9:0], b};
        end
        left_nxt = left_dec;
        if (left_dec == '0) begin
          res_valid       = 1'b1;
          res.body_length = len_e;
          if (ph_e == PH_MBODY) begin
            res.kind      = KIND_META;
            res.meta_kind = hmk_e;
            res.meta_head = head_nxt;
          end else begin
            res.kind = KIND_SYSEX;
          end
        end
      end
      default: begin
        delta_nxt = {delta_e[VLQ_W-8:0], b[6:0]};
        phase_nxt = is_status ? PH_DELTA : PH_STATUS;
      end
    endcase

    if (res_valid) begin
      phase_nxt = PH_DELTA;
      delta_nxt = '0;
      hfd_nxt   = '0;
      hmk_nxt   = '0;
      len_nxt   = '0;
      left_nxt  = '0;
      head_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      rs_r    <= 8'h00;
      delta_r <= '0;
      hfd_r   <= '0;
      hmk_r   <= '0;
      len_r   <= '0;
      left_r  <= '0;
      head_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      rs_r    <= rs_nxt;
      delta_r <= delta_nxt;
      hfd_r   <= hfd_nxt;
      hmk_r   <= hmk_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      head_r  <= head_nxt;
    end
  end

endmodule

@@ src/midi_track_event_parser.sv @@
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Track-chunk byte stream in, one event record out per completed event.
//
//   port group   dir  payload      handshake
//   in_*         in   mtep_in_t    in_valid / in_stall
//   out_*        out  mtep_out_t   out_valid / out_stall
//
// One byte per cycle sustained while no output stall holds the input
// register. The parser update is combinational logic between the input
// register and the output register, which holds each completed record.
// Reset clears the parser state; running status is empty after reset.
// An output stall holds the input register only when the output register
// is full and the input register carries a byte that completes an event.
// ----------------------------------------------------------------------------
module midi_track_event_parser import mtep_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mtep_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output mtep_out_t out_data
);

  logic      ib_valid_r, ib_valid_nxt;
  mtep_in_t  ib_data_r;
  logic      out_valid_r, out_valid_nxt;
  mtep_out_t out_data_r;
  logic      advance;
  logic      res_valid;
  mtep_out_t res;
  logic      in_take;

  mtep_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (ib_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign advance  = ib_valid_r && (!res_valid || !out_valid_r || !out_stall);
  assign in_stall = ib_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    ib_valid_nxt = ib_valid_r;
    if (in_take) begin
      ib_valid_nxt = 1'b1;
    end else if (advance) begin
      ib_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ib_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ib_valid_r  <= ib_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ib_data_r <= in_data;
    end
    if (advance && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && res_valid))
    else $error("input stalled without a blocked record");

  a_record_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid) |=> (out_valid_r && out_data_r == $past(res)))
    else $error("completed event not captured");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !ib_valid_r |-> !in_stall)
    else $error("stall with empty input register");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.kind <= KIND_BAD))
    else $error("record kind out of range");

endmodule
